FILE: hdl/ecsm_pkg.sv
// Package for the elliptic-curve scalar multiplier: widths, register indexes
// and the modular add, subtract and halving helpers shared by the datapath.
// No dependencies.
package ecsm_pkg;

	localparam int FIELD_BITS  = 31;
	localparam int SCALAR_BITS = 32;
	localparam int MCNT_BITS   = $clog2(FIELD_BITS + 1);

	typedef logic [FIELD_BITS-1:0]  field_t;
	typedef logic [SCALAR_BITS-1:0] scalar_t;
	typedef logic                   cfg_index_t;

	localparam cfg_index_t CFG_FIELD_PRIME = 1'b0;
	localparam cfg_index_t CFG_CURVE_COEFF = 1'b1;

	localparam field_t PRIME_RESET = field_t'(31'h7fffffff);
	localparam field_t COEFF_RESET = '0;

	// Both operands below p.
	function automatic field_t fadd(input field_t u, input field_t v, input field_t p);
		field_t room;
		room = p - v;
		return (u >= room) ? field_t'(u - room) : field_t'(u + v);
	endfunction

	function automatic field_t fsub(input field_t u, input field_t v, input field_t p);
		return (u >= v) ? field_t'(u - v) : field_t'(u + (p - v));
	endfunction

	// x/2 modulo an odd p, x below p.
	function automatic field_t fhalf(input field_t x, input field_t p);
		logic [FIELD_BITS:0] s;
		s = x[0] ? ({1'b0, x} + {1'b0, p}) : {1'b0, x};
		return s[FIELD_BITS:1];
	endfunction

endpackage

FILE: hdl/ecsm_if.sv
// Handshake channels of the scalar multiplier: configuration writes, input
// items and result items. Depends on ecsm_pkg.
interface ecsm_cfg_if import ecsm_pkg::*; ();
	logic       valid;
	logic       ready;
	cfg_index_t index;
	field_t     data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

interface ecsm_in_if import ecsm_pkg::*; ();
	logic    valid;
	logic    ready;
	scalar_t scalar;
	field_t  point_x;
	field_t  point_y;
	modport source (output valid, scalar, point_x, point_y, input ready);
	modport sink   (input valid, scalar, point_x, point_y, output ready);
endinterface

interface ecsm_out_if import ecsm_pkg::*; ();
	logic   valid;
	logic   ready;
	field_t result_x;
	field_t result_y;
	logic   result_at_infinity;
	modport source (output valid, result_x, result_y, result_at_infinity, input ready);
	modport sink   (input valid, result_x, result_y, result_at_infinity, output ready);
endinterface

FILE: hdl/ec_scalar_multiply_top.sv
// Elliptic-curve scalar multiplier, affine double-and-add over a prime field.
// Depends on ecsm_pkg and the channel interfaces in ecsm_if.
//
// Use: write field_prime (index 0) and curve_coefficient (index 1) on cfg
// while the block is idle; cfg is always ready. Each request on items carries
// a scalar k and a point; one result, k times the point, leaves on results.
// Infinity comes out as (0,0) with result_at_infinity set.
// Items are worked on one at a time. The three input reductions run on the
// bit-serial multiplier. Each scalar bit costs, if set, an addition and, unless
// it is the top set bit, a doubling; a point operation runs three or four
// bit-serial modular products plus a binary-Euclid inverse.
// The bit-serial multiplier and the one-step-a-cycle inverse set the run time.
// Reset loads p = 2^31-1 and a = 0 and empties the block. The result waits in
// an output register while the receiver stalls; the next request is taken
// meanwhile, and its result waits until the register is free.
module ec_scalar_multiply_top import ecsm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ecsm_cfg_if.sink   cfg,
	ecsm_in_if.sink    items,
	ecsm_out_if.source results
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_RED_A  = 5'd1;
	localparam logic [4:0] S_RED_X  = 5'd2;
	localparam logic [4:0] S_RED_Y  = 5'd3;
	localparam logic [4:0] S_START  = 5'd4;
	localparam logic [4:0] S_LOOP   = 5'd5;
	localparam logic [4:0] S_ADD    = 5'd6;
	localparam logic [4:0] S_SHIFT  = 5'd7;
	localparam logic [4:0] S_DBL    = 5'd8;
	localparam logic [4:0] S_DNUM   = 5'd9;
	localparam logic [4:0] S_DNUM2  = 5'd10;
	localparam logic [4:0] S_INVGO  = 5'd11;
	localparam logic [4:0] S_INV    = 5'd12;
	localparam logic [4:0] S_LAMGO  = 5'd13;
	localparam logic [4:0] S_LSQ    = 5'd14;
	localparam logic [4:0] S_NX     = 5'd15;
	localparam logic [4:0] S_DIF    = 5'd16;
	localparam logic [4:0] S_NY     = 5'd17;
	localparam logic [4:0] S_OUT    = 5'd18;
	localparam logic [4:0] S_MUL    = 5'd19;

	logic [4:0] state_q, ret_q;
	field_t     p_q, a_cfg_q, a_q;
	scalar_t    k_q;
	field_t     xr_q, yr_q;
	field_t     rx_q, ry_q, ax_q, ay_q;
	logic       rinf_q, ainf_q, dst_acc_q;
	field_t     sx_q, sy_q, tx_q, n_q, d_q, l_q, w_q;
	field_t     mu_q, mv_q, macc_q;
	logic [MCNT_BITS-1:0] mcnt_q;
	field_t     iu_q, iv_q, ix1_q, ix2_q;
	logic       ov_q, oinf_q;
	field_t     ox_q, oy_q;

	field_t mdbl, mstep;

	assign cfg.ready   = 1'b1;
	assign items.ready = (state_q == S_IDLE);

	assign results.valid              = ov_q;
	assign results.result_x           = ox_q;
	assign results.result_y           = oy_q;
	assign results.result_at_infinity = oinf_q;

	// One bit of the scalar-style product per cycle, multiplier bits MSB first.
	always_comb begin
		mdbl  = fadd(macc_q, macc_q, p_q);
		mstep = mv_q[FIELD_BITS-1] ? fadd(mdbl, mu_q, p_q) : mdbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q     <= PRIME_RESET;
			a_cfg_q <= COEFF_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FIELD_PRIME: p_q     <= cfg.data;
				CFG_CURVE_COEFF: a_cfg_q <= cfg.data;
				default:         p_q     <= p_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q    <= 1'b0;
		end else begin
			// In S_OUT the output register is reloaded below instead.
			if (ov_q && results.ready && (state_q != S_OUT))
				ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (items.valid) begin
						k_q    <= items.scalar;
						xr_q   <= items.point_x;
						yr_q   <= items.point_y;
						ainf_q <= 1'b1;
						state_q <= (p_q < field_t'(3)) ? S_OUT : S_RED_A;
					end
				end
				S_RED_A: begin
					mu_q <= field_t'(1); mv_q <= a_cfg_q; macc_q <= '0;
					mcnt_q <= MCNT_BITS'(FIELD_BITS); ret_q <= S_RED_X; state_q <= S_MUL;
				end
				S_RED_X: begin
					a_q <= macc_q;
					mu_q <= field_t'(1); mv_q <= xr_q; macc_q <= '0;
					mcnt_q <= MCNT_BITS'(FIELD_BITS); ret_q <= S_RED_Y; state_q <= S_MUL;
				end
				S_RED_Y: begin
					rx_q <= macc_q;
					mu_q <= field_t'(1); mv_q <= yr_q; macc_q <= '0;
					mcnt_q <= MCNT_BITS'(FIELD_BITS); ret_q <= S_START; state_q <= S_MUL;
				end
				S_START: begin
					ry_q    <= macc_q;
					rinf_q  <= (rx_q == '0) && (macc_q == '0);
					state_q <= S_LOOP;
				end
				S_LOOP: begin
					if (k_q == '0)
						state_q <= S_OUT;
					else if (k_q[0])
						state_q <= S_ADD;
					else
						state_q <= S_SHIFT;
				end
				S_ADD: begin
					if (ainf_q) begin
						ax_q <= rx_q; ay_q <= ry_q; ainf_q <= rinf_q;
						state_q <= S_SHIFT;
					end else if (rinf_q) begin
						state_q <= S_SHIFT;
					end else if (ax_q == rx_q) begin
						if (ay_q == ry_q) begin
							// Both points are equal, so doubling the running point serves.
							dst_acc_q <= 1'b1;
							state_q   <= S_DBL;
						end else begin
							ainf_q  <= 1'b1;
							state_q <= S_SHIFT;
						end
					end else begin
						sx_q <= ax_q; sy_q <= ay_q; tx_q <= rx_q;
						n_q  <= fsub(ry_q, ay_q, p_q);
						d_q  <= fsub(rx_q, ax_q, p_q);
						dst_acc_q <= 1'b1;
						state_q   <= S_INVGO;
					end
				end
				S_SHIFT: begin
					k_q <= k_q >> 1;
					if (k_q[SCALAR_BITS-1:1] != '0) begin
						dst_acc_q <= 1'b0;
						state_q   <= S_DBL;
					end else begin
						state_q <= S_LOOP;
					end
				end
				S_DBL: begin
					if (rinf_q || (ry_q == '0)) begin
						if (dst_acc_q) begin
							ainf_q  <= 1'b1;
							state_q <= S_SHIFT;
						end else begin
							rinf_q  <= 1'b1;
							state_q <= S_LOOP;
						end
					end else begin
						sx_q <= rx_q; sy_q <= ry_q; tx_q <= rx_q;
						d_q  <= fadd(ry_q, ry_q, p_q);
						mu_q <= rx_q; mv_q <= rx_q; macc_q <= '0;
						mcnt_q <= MCNT_BITS'(FIELD_BITS); ret_q <= S_DNUM; state_q <= S_MUL;
					end
				end
				S_DNUM: begin
					n_q     <= fadd(fadd(macc_q, macc_q, p_q), macc_q, p_q);
					state_q <= S_DNUM2;
				end
				S_DNUM2: begin
					n_q     <= fadd(n_q, a_q, p_q);
					state_q <= S_INVGO;
				end
				S_INVGO: begin
					iu_q <= d_q; iv_q <= p_q; ix1_q <= field_t'(1); ix2_q <= '0;
					state_q <= S_INV;
				end
				S_INV: begin
					// Binary extended Euclid; u reaching zero means no inverse.
					if (iu_q == '0) begin
						d_q <= '0; state_q <= S_LAMGO;
					end else if (iu_q == field_t'(1)) begin
						d_q <= ix1_q; state_q <= S_LAMGO;
					end else if (iv_q == field_t'(1)) begin
						d_q <= ix2_q; state_q <= S_LAMGO;
					end else if (!iu_q[0]) begin
						iu_q <= iu_q >> 1; ix1_q <= fhalf(ix1_q, p_q);
					end else if (!iv_q[0]) begin
						iv_q <= iv_q >> 1; ix2_q <= fhalf(ix2_q, p_q);
					end else if (iu_q >= iv_q) begin
						iu_q <= iu_q - iv_q; ix1_q <= fsub(ix1_q, ix2_q, p_q);
					end else begin
						iv_q <= iv_q - iu_q; ix2_q <= fsub(ix2_q, ix1_q, p_q);
					end
				end
				S_LAMGO: begin
					mu_q <= n_q; mv_q <= d_q; macc_q <= '0;
					mcnt_q <= MCNT_BITS'(FIELD_BITS); ret_q <= S_LSQ; state_q <= S_MUL;
				end
				S_LSQ: begin
					l_q  <= macc_q;
					mu_q <= macc_q; mv_q <= macc_q; macc_q <= '0;
					mcnt_q <= MCNT_BITS'(FIELD_BITS); ret_q <= S_NX; state_q <= S_MUL;
				end
				S_NX: begin
					w_q     <= fsub(fsub(macc_q, sx_q, p_q), tx_q, p_q);
					state_q <= S_DIF;
				end
				S_DIF: begin
					mu_q <= l_q; mv_q <= fsub(sx_q, w_q, p_q); macc_q <= '0;
					mcnt_q <= MCNT_BITS'(FIELD_BITS); ret_q <= S_NY; state_q <= S_MUL;
				end
				S_NY: begin
					if (dst_acc_q) begin
						ax_q <= w_q; ay_q <= fsub(macc_q, sy_q, p_q); ainf_q <= 1'b0;
						state_q <= S_SHIFT;
					end else begin
						rx_q <= w_q; ry_q <= fsub(macc_q, sy_q, p_q); rinf_q <= 1'b0;
						state_q <= S_LOOP;
					end
				end
				S_OUT: begin
					if (!ov_q || results.ready) begin
						ov_q    <= 1'b1;
						ox_q    <= ainf_q ? '0 : ax_q;
						oy_q    <= ainf_q ? '0 : ay_q;
						oinf_q  <= ainf_q;
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					macc_q <= mstep;
					mv_q   <= mv_q << 1;
					mcnt_q <= mcnt_q - MCNT_BITS'(1);
					if (mcnt_q == MCNT_BITS'(1))
						state_q <= ret_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/ecsm_checker.sv
// Port-level checks for the scalar multiplier, bound to its top level.
// Depends on ecsm_pkg and ec_scalar_multiply_top.
module ecsm_assert import ecsm_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   cfg_valid,
	input logic   cfg_ready,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input field_t out_x,
	input field_t out_y,
	input logic   out_inf
);

	// A pending result is not withdrawn.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// Only one item is worked on at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_inf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_inf |-> (out_x == '0) && (out_y == '0))
		else $error("infinity result with nonzero coordinates");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind ec_scalar_multiply_top ecsm_assert u_ecsm_assert (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_x     (results.result_x),
	.out_y     (results.result_y),
	.out_inf   (results.result_at_infinity)
);

FILE: sim/ecsm_checker.sv
// Checker for the scalar multiplier: watches the config, item and result channels.
// It predicts k times the point for each accepted item and compares the results.
// Depends on ecsm_pkg and the channel interfaces in ecsm_if.
module ecsm_checker import ecsm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ecsm_cfg_if    cfg,
	ecsm_in_if     items,
	ecsm_out_if    results,
	output int     failures,
	output int     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [63:0] x;
		logic [63:0] y;
		bit          inf;
	} affine_pt_t;

	typedef struct {
		field_t x;
		field_t y;
		logic   inf;
	} product_t;

	logic [63:0] prime;
	logic [63:0] coeff;
	product_t    expected_products[$];

	function automatic logic [63:0] mod_add(logic [63:0] u, logic [63:0] v, logic [63:0] p);
		return (u + v) % p;
	endfunction

	function automatic logic [63:0] mod_sub(logic [63:0] u, logic [63:0] v, logic [63:0] p);
		return (u >= v) ? u - v : u + (p - v);
	endfunction

	function automatic logic [63:0] mod_mul(logic [63:0] u, logic [63:0] v, logic [63:0] p);
		return (u * v) % p;
	endfunction

	// Extended Euclid; zero when u has no inverse modulo p.
	function automatic logic [63:0] mod_inv(logic [63:0] u, logic [63:0] p);
		longint r0, r1, t0, t1, q, tmp;
		r0 = longint'(p);
		r1 = longint'(u);
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q = r0 / r1;
			tmp = r0 - q * r1;
			r0 = r1;
			r1 = tmp;
			tmp = t0 - q * t1;
			t0 = t1;
			t1 = tmp;
		end
		if (r0 != 1)
			return 64'(0);
		t0 = t0 % longint'(p);
		if (t0 < 0)
			t0 = t0 + longint'(p);
		return 64'(t0);
	endfunction

	function automatic affine_pt_t pt_at_infinity();
		affine_pt_t r;
		r.x = 0;
		r.y = 0;
		r.inf = 1;
		return r;
	endfunction

	function automatic affine_pt_t pt_dbl(affine_pt_t s, logic [63:0] a, logic [63:0] p);
		affine_pt_t r;
		logic [63:0] xx, num, lam;
		if (s.inf || s.y == 0)
			return pt_at_infinity();
		xx = mod_mul(s.x, s.x, p);
		num = mod_add(mod_add(mod_add(xx, xx, p), xx, p), a, p);
		lam = mod_mul(num, mod_inv(mod_add(s.y, s.y, p), p), p);
		r.x = mod_sub(mod_sub(mod_mul(lam, lam, p), s.x, p), s.x, p);
		r.y = mod_sub(mod_mul(lam, mod_sub(s.x, r.x, p), p), s.y, p);
		r.inf = 0;
		return r;
	endfunction

	function automatic affine_pt_t pt_sum(affine_pt_t s, affine_pt_t t, logic [63:0] a,
			logic [63:0] p);
		affine_pt_t r;
		logic [63:0] lam;
		if (s.inf)
			return t;
		if (t.inf)
			return s;
		if (s.x == t.x) begin
			if (s.y == t.y)
				return pt_dbl(s, a, p);
			return pt_at_infinity();
		end
		lam = mod_mul(mod_sub(t.y, s.y, p), mod_inv(mod_sub(t.x, s.x, p), p), p);
		r.x = mod_sub(mod_sub(mod_mul(lam, lam, p), s.x, p), t.x, p);
		r.y = mod_sub(mod_mul(lam, mod_sub(s.x, r.x, p), p), s.y, p);
		r.inf = 0;
		return r;
	endfunction

	function automatic product_t scalar_product(scalar_t k_in, field_t px, field_t py);
		product_t    res;
		affine_pt_t  acc, run;
		logic [63:0] k, a;
		acc = pt_at_infinity();
		k = 64'(k_in);
		if (prime >= 3) begin
			a = coeff % prime;
			run.x = 64'(px) % prime;
			run.y = 64'(py) % prime;
			run.inf = (run.x == 0 && run.y == 0);
			while (k != 0) begin
				if (k[0])
					acc = pt_sum(acc, run, a, prime);
				k = k >> 1;
				if (k != 0)
					run = pt_dbl(run, a, prime);
			end
		end
		res.x = acc.inf ? '0 : field_t'(acc.x);
		res.y = acc.inf ? '0 : field_t'(acc.y);
		res.inf = acc.inf;
		return res;
	endfunction

	assign outstanding = expected_products.size();

	always @(posedge clk or negedge arst_n) begin
		product_t want;
		if (!arst_n) begin
			prime = 64'(PRIME_RESET);
			coeff = 64'(COEFF_RESET);
			failures = 0;
			expected_products.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_FIELD_PRIME)
					prime = 64'(cfg.data);
				else
					coeff = 64'(cfg.data);
			end
			if (items.valid && items.ready)
				expected_products.push_back(scalar_product(items.scalar, items.point_x,
					items.point_y));
			if (results.valid && results.ready) begin
				if (expected_products.size() == 0) begin
					$display("%0t: unexpected result x=%0d y=%0d inf=%0b", $time,
						results.result_x, results.result_y, results.result_at_infinity);
					failures++;
				end else begin
					want = expected_products.pop_front();
					if (results.result_x !== want.x) begin
						$display("%0t: result_x expected %0d actual %0d", $time, want.x,
							results.result_x);
						failures++;
					end
					if (results.result_y !== want.y) begin
						$display("%0t: result_y expected %0d actual %0d", $time, want.y,
							results.result_y);
						failures++;
					end
					if (results.result_at_infinity !== want.inf) begin
						$display("%0t: result_at_infinity expected %0b actual %0b", $time,
							want.inf, results.result_at_infinity);
						failures++;
					end
				end
			end
		end
	end

endmodule

FILE: sim/ec_scalar_multiply_top_tb.sv
// Testbench top for the scalar multiplier: clock, reset, config writes, item
// stimulus under varying idle and stall patterns, and the verdict.
// Depends on ecsm_pkg, ecsm_if, ec_scalar_multiply_top and ecsm_checker.
module ec_scalar_multiply_top_tb import ecsm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 12_000_000;

	logic clk;
	logic arst_n;
	int   failures;
	int   outstanding;
	int   sender_idle_pct;
	int   receiver_stall_pct;
	longint cycles;

	ecsm_cfg_if cfg ();
	ecsm_in_if  items ();
	ecsm_out_if results ();

	ec_scalar_multiply_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.items   (items),
		.results (results)
	);

	ecsm_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.items       (items),
		.results     (results),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial clk = 0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk)
		results.ready <= ($urandom_range(99) >= receiver_stall_pct);

	task automatic write_register(cfg_index_t idx, field_t value);
		cfg.valid <= 1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
		@(posedge clk);
	endtask

	// Holds valid across back-to-back requests; drops it only for idle gaps.
	task automatic send_item(scalar_t k, field_t px, field_t py);
		if ($urandom_range(99) < sender_idle_pct) begin
			items.valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		items.valid   <= 1;
		items.scalar  <= k;
		items.point_x <= px;
		items.point_y <= py;
		do @(posedge clk); while (!items.ready);
	endtask

	task automatic settle_and_configure(field_t p, field_t a);
		items.valid <= 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		write_register(CFG_FIELD_PRIME, p);
		write_register(CFG_CURVE_COEFF, a);
	endtask

	task automatic send_random_items(int count);
		scalar_t k;
		field_t  px, py;
		repeat (count) begin
			// Long scalars are slow, so most requests use short ones.
			k = ($urandom_range(3) == 0) ? scalar_t'($urandom) : scalar_t'($urandom_range(4095));
			px = field_t'($urandom_range(2147483646));
			py = field_t'($urandom_range(2147483646));
			case ($urandom_range(9))
				0: px = '0;
				1: py = '0;
				2: px = field_t'($urandom_range(20));
				3: py = field_t'(2147483646);
				default: ;
			endcase
			send_item(k, px, py);
		end
	endtask

	initial begin
		field_t primes[6];
		field_t coeffs[6];
		primes = '{field_t'(2147483647), field_t'(3), field_t'(2147483647),
			field_t'(1000003), field_t'(221), field_t'(65521)};
		coeffs = '{field_t'(0), field_t'(2147483646), field_t'(2147483646),
			field_t'(7), field_t'(5), field_t'(0)};
		cycles = 0;
		arst_n = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		cfg.valid = 0;
		cfg.index = CFG_FIELD_PRIME;
		cfg.data = '0;
		items.valid = 0;
		items.scalar = '0;
		items.point_x = '0;
		items.point_y = '0;
		results.ready = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed requests under the reset configuration.
		send_item('0, field_t'(5), field_t'(9));
		send_item(scalar_t'(1), '0, '0);
		send_item(scalar_t'(32'hffffffff), '0, '0);
		send_item(scalar_t'(1), field_t'(2147483646), field_t'(2147483646));
		send_item(scalar_t'(2), field_t'(12345), '0);
		send_item(scalar_t'(3), field_t'(7), '0);
		send_item(scalar_t'(32'hffffffff), field_t'(2147483646), field_t'(1));
		send_item(scalar_t'(32'h80000000), field_t'(3), field_t'(4));
		send_item(scalar_t'(2), '0, field_t'(1));
		send_item(scalar_t'(5), field_t'(1), '0);

		for (int ph = 0; ph < 6; ph++) begin
			settle_and_configure(primes[ph], coeffs[ph]);
			case (ph % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 84; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 84; end
				default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
			endcase
			// Small primes get two extra requests; the first has operands above the prime to exercise the input reduction.
			if (primes[ph] < 1000) begin
				send_item(scalar_t'(2), field_t'(2147483646), field_t'(2147483646));
				send_item(scalar_t'(3), field_t'(1), field_t'(1));
			end
			send_random_items(15);
		end

		items.valid <= 0;
		while (outstanding != 0)
			@(posedge clk);
		receiver_stall_pct = 0;
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: ec_scalar_multiply_top.f
hdl/ecsm_pkg.sv
hdl/ecsm_if.sv
hdl/ec_scalar_multiply_top.sv
hdl/ecsm_checker.sv
sim/ecsm_checker.sv
sim/ec_scalar_multiply_top_tb.sv
